FILE: hw/rtl/vrd_pkg.sv
// vrd_pkg: shared types, constants and lookup tables for the vector rotator.
// Used by every module under hw/rtl; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package vrd_pkg;

   localparam int WORD_WIDTH    = 32;
   localparam int CORDIC_STAGES = 24;
   localparam int N_ITER        = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;

   localparam int GUARD_BITS = (WORD_WIDTH / 4 > 28) ? 28 : WORD_WIDTH / 4;
   localparam int GAIN_SHIFT = 30 - GUARD_BITS;
   localparam int DATA_W     = 34 + GUARD_BITS;
   localparam int EXT_W      = DATA_W + 1;
   localparam int Z_W        = 33;
   localparam int CEIL_SHIFT = 16 + GUARD_BITS;

   // inverse CORDIC gain, Q1.30
   localparam longint GAIN_INV   = 64'sd652032874;
   localparam longint GAIN_ROUND = 64'sd1 <<< (GAIN_SHIFT - 1);

   // angle reduction: one turn is 360.0 in Q16.16
   localparam longint TURN        = 64'sd23592960;
   localparam longint TURN_RECIP  = (64'sd1 <<< 32) / TURN;
   localparam longint TURN_OFFSET = (64'sd1 <<< 31) % TURN;
   localparam int     TURN_W      = 25;
   localparam int     REM_W       = 26;
   localparam int     QT_W        = 8;

   // binary angle = q * 2^13 + frac_entry(rem), q and rem taken against 45
   localparam longint BAM_DIV       = 64'sd45;
   localparam longint BAM_DIV_RECIP = (64'sd1 <<< 31) / BAM_DIV;
   localparam int     BAM_Q_W       = 19;
   localparam int     FRAC_W        = 13;
   localparam int     BAM_R_W       = 6;
   localparam int     PROD45_W      = 51;

   localparam longint QUARTER_TURN = 64'sd1 <<< 30;
   localparam longint HALF_TURN    = 64'sd1 <<< 31;

   localparam longint ROUND_HALF = (GUARD_BITS > 0) ? (64'sd1 <<< (GUARD_BITS - 1)) : 64'sd0;
   localparam longint CEIL_BIAS  = (64'sd1 <<< CEIL_SHIFT) - 64'sd1;
   localparam longint INT32_MAX  = 64'sd2147483647;
   localparam longint INT32_MIN  = -64'sd2147483648;
   localparam longint WHOLE_MAX  = 64'sd32767;
   localparam longint WHOLE_MIN  = -64'sd32768;

   localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_NEG = 32'h8000_0000;

   typedef struct packed {
      logic               mode;
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] angle_deg;
   } vrd_req_type;

   typedef struct packed {
      logic signed [31:0] rotated_x;
      logic signed [31:0] rotated_y;
      logic               saturated;
   } vrd_rsp_type;

   typedef struct packed {
      logic                    mode;
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic signed [Z_W-1:0]    z;
   } vrd_rot_type;

   // atan(2^-i) as 32-bit binary angles
   function automatic logic [31:0] atan_entry(input int unsigned idx);
      logic [31:0] a;
      case (idx)
         0:       a = 32'h20000000;
         1:       a = 32'h12E4051E;
         2:       a = 32'h09FB385B;
         3:       a = 32'h051111D4;
         4:       a = 32'h028B0D43;
         5:       a = 32'h0145D7E1;
         6:       a = 32'h00A2F61E;
         7:       a = 32'h00517C55;
         8:       a = 32'h0028BE53;
         9:       a = 32'h00145F2F;
         10:      a = 32'h000A2F98;
         11:      a = 32'h000517CC;
         12:      a = 32'h00028BE6;
         13:      a = 32'h000145F3;
         14:      a = 32'h0000A2FA;
         15:      a = 32'h0000517D;
         16:      a = 32'h000028BE;
         17:      a = 32'h0000145F;
         18:      a = 32'h00000A30;
         19:      a = 32'h00000518;
         20:      a = 32'h0000028C;
         21:      a = 32'h00000146;
         22:      a = 32'h000000A3;
         23:      a = 32'h00000051;
         24:      a = 32'h00000029;
         25:      a = 32'h00000014;
         26:      a = 32'h0000000A;
         27:      a = 32'h00000005;
         28:      a = 32'h00000003;
         29:      a = 32'h00000001;
         30:      a = 32'h00000001;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

   // floor((rem * 8192 + 22) / 45) for rem in 0..44
   function automatic logic [FRAC_W-1:0] frac_entry(input logic [BAM_R_W-1:0] idx);
      logic [FRAC_W-1:0] f;
      case (idx)
         6'd0:    f = 13'd0;
         6'd1:    f = 13'd182;
         6'd2:    f = 13'd364;
         6'd3:    f = 13'd546;
         6'd4:    f = 13'd728;
         6'd5:    f = 13'd910;
         6'd6:    f = 13'd1092;
         6'd7:    f = 13'd1274;
         6'd8:    f = 13'd1456;
         6'd9:    f = 13'd1638;
         6'd10:   f = 13'd1820;
         6'd11:   f = 13'd2002;
         6'd12:   f = 13'd2185;
         6'd13:   f = 13'd2367;
         6'd14:   f = 13'd2549;
         6'd15:   f = 13'd2731;
         6'd16:   f = 13'd2913;
         6'd17:   f = 13'd3095;
         6'd18:   f = 13'd3277;
         6'd19:   f = 13'd3459;
         6'd20:   f = 13'd3641;
         6'd21:   f = 13'd3823;
         6'd22:   f = 13'd4005;
         6'd23:   f = 13'd4187;
         6'd24:   f = 13'd4369;
         6'd25:   f = 13'd4551;
         6'd26:   f = 13'd4733;
         6'd27:   f = 13'd4915;
         6'd28:   f = 13'd5097;
         6'd29:   f = 13'd5279;
         6'd30:   f = 13'd5461;
         6'd31:   f = 13'd5643;
         6'd32:   f = 13'd5825;
         6'd33:   f = 13'd6007;
         6'd34:   f = 13'd6190;
         6'd35:   f = 13'd6372;
         6'd36:   f = 13'd6554;
         6'd37:   f = 13'd6736;
         6'd38:   f = 13'd6918;
         6'd39:   f = 13'd7100;
         6'd40:   f = 13'd7282;
         6'd41:   f = 13'd7464;
         6'd42:   f = 13'd7646;
         6'd43:   f = 13'd7828;
         6'd44:   f = 13'd8010;
         default: f = 13'd0;
      endcase
      return f;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/vrd_front.sv
// vrd_front: six-stage front end - gain pre-scaling, angle reduction to a
// binary angle and quadrant fold. Depends on vrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vrd_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  advance,
   input  wire                  req_valid,
   input  vrd_pkg::vrd_req_type req_payload,
   output logic                 out_valid,
   output vrd_pkg::vrd_rot_type out_data
);

   logic [5:0] vld_ff;

   logic                              mode_ff [5];
   logic signed [vrd_pkg::DATA_W-1:0] x_ff [5];
   logic signed [vrd_pkg::DATA_W-1:0] y_ff [5];
   logic                              mode_in;
   logic signed [vrd_pkg::DATA_W-1:0] x_in, y_in;

   logic [31:0]                  u_ff, u_in;
   logic [vrd_pkg::QT_W-1:0]     qt_ff, qt_in;
   logic [vrd_pkg::REM_W-1:0]    rem0_ff, rem0_in;
   logic [vrd_pkg::TURN_W-1:0]   r3_ff, r3_in;
   logic [vrd_pkg::TURN_W-1:0]   r4_ff;
   logic [vrd_pkg::BAM_Q_W-1:0]  qe_ff, qe_in;
   logic [vrd_pkg::BAM_Q_W-1:0]  q5_ff, q5_in;
   logic [vrd_pkg::BAM_R_W-1:0]  f5_ff, f5_in;
   vrd_pkg::vrd_rot_type         rot_ff, rot_in;

   logic [39:0]                   tq;
   logic signed [63:0]            px, py, pxr, pyr;
   logic [31:0]                   d2;
   logic [vrd_pkg::REM_W-1:0]     rm, red;
   logic [vrd_pkg::PROD45_W-1:0]  pr;
   logic [vrd_pkg::TURN_W-1:0]    d5;
   logic [31:0]                   bam;
   logic signed [vrd_pkg::Z_W-1:0] z0;

   // stage 1: offset angle to unsigned, quotient estimate, gain multiply
   always_comb begin
      u_in    = {~req_payload.angle_deg[31], req_payload.angle_deg[30:0]};
      tq      = 40'(u_in) * 40'(vrd_pkg::TURN_RECIP);
      qt_in   = tq[39:32];
      px      = 64'(req_payload.vec_x) * 64'(vrd_pkg::GAIN_INV);
      py      = 64'(req_payload.vec_y) * 64'(vrd_pkg::GAIN_INV);
      pxr     = (px + vrd_pkg::GAIN_ROUND) >>> vrd_pkg::GAIN_SHIFT;
      pyr     = (py + vrd_pkg::GAIN_ROUND) >>> vrd_pkg::GAIN_SHIFT;
      x_in    = pxr[vrd_pkg::DATA_W-1:0];
      y_in    = pyr[vrd_pkg::DATA_W-1:0];
      mode_in = req_payload.mode;
   end

   // stage 2: remainder against one turn, below two turns
   always_comb begin
      d2      = u_ff - 32'(qt_ff) * 32'(vrd_pkg::TURN);
      rem0_in = d2[vrd_pkg::REM_W-1:0];
   end

   // stage 3: final correction and removal of the 2^31 offset
   always_comb begin
      rm  = (rem0_ff >= vrd_pkg::REM_W'(vrd_pkg::TURN)) ?
            rem0_ff - vrd_pkg::REM_W'(vrd_pkg::TURN) : rem0_ff;
      red = (rm >= vrd_pkg::REM_W'(vrd_pkg::TURN_OFFSET)) ?
            rm - vrd_pkg::REM_W'(vrd_pkg::TURN_OFFSET) :
            rm + vrd_pkg::REM_W'(vrd_pkg::TURN - vrd_pkg::TURN_OFFSET);
      r3_in = red[vrd_pkg::TURN_W-1:0];
   end

   // stage 4: quotient estimate against 45
   always_comb begin
      pr    = vrd_pkg::PROD45_W'(r3_ff) * vrd_pkg::PROD45_W'(vrd_pkg::BAM_DIV_RECIP);
      qe_in = pr[vrd_pkg::BAM_Q_W+30:31];
   end

   // stage 5: remainder against 45 with one correction
   always_comb begin
      d5 = r4_ff - vrd_pkg::TURN_W'(qe_ff) * vrd_pkg::TURN_W'(vrd_pkg::BAM_DIV);
      if (d5[6:0] >= 7'(vrd_pkg::BAM_DIV)) begin
         q5_in = qe_ff + 1'b1;
         f5_in = vrd_pkg::BAM_R_W'(d5[6:0] - 7'(vrd_pkg::BAM_DIV));
      end else begin
         q5_in = qe_ff;
         f5_in = d5[vrd_pkg::BAM_R_W-1:0];
      end
   end

   // stage 6: binary angle, negation, fold into [-90, +90] degrees
   always_comb begin
      bam         = {q5_ff, vrd_pkg::frac_entry(f5_ff)};
      bam         = 32'd0 - bam;
      z0          = {bam[31], bam};
      rot_in.mode = mode_ff[4];
      rot_in.x    = x_ff[4];
      rot_in.y    = y_ff[4];
      rot_in.z    = z0;
      if (z0 > vrd_pkg::Z_W'(vrd_pkg::QUARTER_TURN)) begin
         rot_in.z = z0 - vrd_pkg::Z_W'(vrd_pkg::HALF_TURN);
         rot_in.x = -x_ff[4];
         rot_in.y = -y_ff[4];
      end else if (z0 < -vrd_pkg::Z_W'(vrd_pkg::QUARTER_TURN)) begin
         rot_in.z = z0 + vrd_pkg::Z_W'(vrd_pkg::HALF_TURN);
         rot_in.x = -x_ff[4];
         rot_in.y = -y_ff[4];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[4:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mode_ff[0] <= mode_in;
         x_ff[0]    <= x_in;
         y_ff[0]    <= y_in;
         for (int k = 1; k < 5; k++) begin
            mode_ff[k] <= mode_ff[k-1];
            x_ff[k]    <= x_ff[k-1];
            y_ff[k]    <= y_ff[k-1];
         end
         u_ff    <= u_in;
         qt_ff   <= qt_in;
         rem0_ff <= rem0_in;
         r3_ff   <= r3_in;
         r4_ff   <= r3_ff;
         qe_ff   <= qe_in;
         q5_ff   <= q5_in;
         f5_ff   <= f5_in;
         rot_ff  <= rot_in;
      end
   end

   assign out_valid = vld_ff[5];
   assign out_data  = rot_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/vrd_cordic.sv
// vrd_cordic: rotation-mode CORDIC, one registered stage per iteration.
// Depends on vrd_pkg for the data type and arctangent table.
`timescale 1ns / 1ps
`default_nettype none

module vrd_cordic (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  advance,
   input  wire                  in_valid,
   input  vrd_pkg::vrd_rot_type in_data,
   output logic                 out_valid,
   output vrd_pkg::vrd_rot_type out_data
);

   vrd_pkg::vrd_rot_type            stg_ff [vrd_pkg::N_ITER];
   logic [vrd_pkg::N_ITER-1:0]      vld_ff;

   genvar i;
   for (i = 0; i < vrd_pkg::N_ITER; i++) begin : g_iter
      vrd_pkg::vrd_rot_type cur;
      vrd_pkg::vrd_rot_type nxt_in;

      if (i == 0) begin : g_first
         assign cur = in_data;
      end else begin : g_next
         assign cur = stg_ff[i-1];
      end

      always_comb begin
         logic signed [vrd_pkg::DATA_W-1:0] xs;
         logic signed [vrd_pkg::DATA_W-1:0] ys;
         xs          = $signed(cur.x) >>> i;
         ys          = $signed(cur.y) >>> i;
         nxt_in.mode = cur.mode;
         if (!cur.z[vrd_pkg::Z_W-1]) begin
            nxt_in.x = cur.x - ys;
            nxt_in.y = cur.y + xs;
            nxt_in.z = cur.z - vrd_pkg::Z_W'(vrd_pkg::atan_entry(i));
         end else begin
            nxt_in.x = cur.x + ys;
            nxt_in.y = cur.y - xs;
            nxt_in.z = cur.z + vrd_pkg::Z_W'(vrd_pkg::atan_entry(i));
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            stg_ff[i] <= nxt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[vrd_pkg::N_ITER-2:0], in_valid};
      end
   end

   assign out_valid = vld_ff[vrd_pkg::N_ITER-1];
   assign out_data  = stg_ff[vrd_pkg::N_ITER-1];

endmodule

`default_nettype wire

FILE: hw/rtl/vrd_out_buffer.sv
// vrd_out_buffer: output rounding/ceiling and saturation into a result
// register with one skid entry; drives the pipeline advance. Depends on vrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vrd_out_buffer (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_valid,
   input  vrd_pkg::vrd_rot_type in_data,
   output logic                 advance,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output vrd_pkg::vrd_rsp_type rsp_payload
);

   logic                 main_vld_ff, main_vld_in;
   logic                 skid_vld_ff, skid_vld_in;
   vrd_pkg::vrd_rsp_type main_ff, main_in;
   vrd_pkg::vrd_rsp_type skid_ff, skid_in;
   vrd_pkg::vrd_rsp_type new_rsp;
   logic [32:0]          rx, ry;
   logic                 push;
   logic                 main_free;

   // {saturated, value}
   function automatic logic [32:0] round_sat(input logic signed [vrd_pkg::DATA_W-1:0] v,
                                             input logic ceil_mode);
      logic signed [vrd_pkg::EXT_W-1:0] ve;
      logic signed [vrd_pkg::EXT_W-1:0] t;
      logic [31:0]                      res;
      logic                             sat;
      ve  = {v[vrd_pkg::DATA_W-1], v};
      sat = 1'b0;
      if (ceil_mode) begin
         t = (ve + vrd_pkg::EXT_W'(vrd_pkg::CEIL_BIAS)) >>> vrd_pkg::CEIL_SHIFT;
         if (t > vrd_pkg::EXT_W'(vrd_pkg::WHOLE_MAX)) begin
            sat = 1'b1;
            res = vrd_pkg::SAT_POS;
         end else if (t < vrd_pkg::EXT_W'(vrd_pkg::WHOLE_MIN)) begin
            sat = 1'b1;
            res = vrd_pkg::SAT_NEG;
         end else begin
            res = {t[15:0], 16'h0000};
         end
      end else begin
         t = (ve + vrd_pkg::EXT_W'(vrd_pkg::ROUND_HALF)) >>> vrd_pkg::GUARD_BITS;
         if (t > vrd_pkg::EXT_W'(vrd_pkg::INT32_MAX)) begin
            sat = 1'b1;
            res = vrd_pkg::SAT_POS;
         end else if (t < vrd_pkg::EXT_W'(vrd_pkg::INT32_MIN)) begin
            sat = 1'b1;
            res = vrd_pkg::SAT_NEG;
         end else begin
            res = t[31:0];
         end
      end
      return {sat, res};
   endfunction

   assign advance = !skid_vld_ff;
   assign push    = advance && in_valid;

   always_comb begin
      rx                = round_sat(in_data.x, in_data.mode);
      ry                = round_sat(in_data.y, in_data.mode);
      new_rsp.rotated_x = rx[31:0];
      new_rsp.rotated_y = ry[31:0];
      new_rsp.saturated = rx[32] | ry[32];
   end

   always_comb begin
      main_free = !main_vld_ff || !rsp_stall;
      skid_in   = skid_ff;
      if (main_free) begin
         main_vld_in = skid_vld_ff || push;
         main_in     = skid_vld_ff ? skid_ff : new_rsp;
         skid_vld_in = 1'b0;
      end else begin
         main_vld_in = 1'b1;
         main_in     = main_ff;
         skid_vld_in = skid_vld_ff || push;
         if (push) begin
            skid_in = new_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         main_vld_ff <= main_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid   = main_vld_ff;
   assign rsp_payload = main_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/vector2_rotate_by_degrees.sv
// vector2_rotate_by_degrees: rotates a Q16.16 vector by minus an angle in
// degrees using a pipelined CORDIC.
// Channels: req_ (mode, vec_x, vec_y, angle_deg) in, rsp_ (rotated_x,
// rotated_y, saturated) out, each a valid/stall pair; a transfer happens on a
// rising edge with valid high and stall low.
// Pipeline: 6 front-end stages for gain scaling, angle reduction and fold,
// 24 CORDIC stages, 1 result register. Throughput: one transfer per cycle,
// sustained while rsp_stall is low; each stage is one register.
// Mode 0 rounds to Q16.16, mode 1 takes the ceiling to whole units; results
// out of range clamp and raise saturated.
// Reset (synchronous) empties the pipeline and result register.
// Receiver stall: the result register holds; one more result lands in the
// skid entry, after which req_stall rises and the pipeline freezes without
// losing any item. Depends on vrd_pkg, vrd_front, vrd_cordic, vrd_out_buffer.
`timescale 1ns / 1ps
`default_nettype none

module vector2_rotate_by_degrees (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  vrd_pkg::vrd_req_type req_payload,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output vrd_pkg::vrd_rsp_type rsp_payload
);

   logic                 advance;
   logic                 front_valid;
   vrd_pkg::vrd_rot_type front_data;
   logic                 cordic_valid;
   vrd_pkg::vrd_rot_type cordic_data;

   assign req_stall = !advance;

   vrd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .out_valid   (front_valid),
      .out_data    (front_data)
   );

   vrd_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (cordic_valid),
      .out_data  (cordic_data)
   );

   vrd_out_buffer u_out (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (cordic_valid),
      .in_data     (cordic_data),
      .advance     (advance),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

FILE: bench/tb_vector2_rotate_by_degrees.sv
// tb_vector2_rotate_by_degrees: self-checking bench for the CORDIC vector rotator.
// Drives a directed table and then random vectors with random gaps and back-pressure.
// Every result is checked against a local bit-exact model or its typed row; depends on vrd_pkg and the RTL.
`timescale 1ns / 1ps

module tb_vector2_rotate_by_degrees;

   localparam int     N_STAGES       = (vrd_pkg::CORDIC_STAGES < 32) ? vrd_pkg::CORDIC_STAGES : 32;
   localparam int     GUARD          = (vrd_pkg::WORD_WIDTH / 4 > 28) ? 28 : vrd_pkg::WORD_WIDTH / 4;
   localparam int     GAIN_SH        = 30 - GUARD;
   localparam int     CEIL_SH        = 16 + GUARD;
   localparam longint K_INV          = 64'sd652032874;
   localparam longint DEG_TURN       = 64'sd23592960;
   localparam longint QUARTER        = 64'sd1 <<< 30;
   localparam longint HALF           = 64'sd1 <<< 31;
   localparam int     N_RANDOM       = 950;
   localparam int     N_DIRECTED     = 22;
   localparam int     WATCHDOG_LIMIT = 2000;
   localparam int     DRAIN_CYCLES   = 64;

   localparam longint ATAN_TAB [32] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
      64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
      64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005,
      64'h00000003, 64'h00000001, 64'h00000001, 64'h00000000
   };

   typedef struct packed {
      logic                 typed;
      vrd_pkg::vrd_req_type req;
      vrd_pkg::vrd_rsp_type want;
   } job_type;

   // typed rows carry their own result; the rest go through the model
   localparam job_type DIRECTED_JOBS [N_DIRECTED] = '{
      '{1'b1, '{1'b0, 32'h00000000, 32'h00000000, 32'h00000000}, '{32'h0, 32'h0, 1'b0}},
      '{1'b1, '{1'b1, 32'h00000000, 32'h00000000, 32'h7FFFFFFF}, '{32'h0, 32'h0, 1'b0}},
      '{1'b1, '{1'b0, 32'h00000000, 32'h00000000, 32'h80000000}, '{32'h0, 32'h0, 1'b0}},
      '{1'b0, '{1'b0, 32'h00010000, 32'h00000000, 32'h00000000}, '{32'h0, 32'h0, 1'b0}},
      '{1'b0, '{1'b0, 32'h00010000, 32'h00000000, 32'h005A0000}, '{32'h0, 32'h0, 1'b0}},
      '{1'b0, '{1'b0, 32'h00010000, 32'h00000000, 32'h00B40000}, '{32'h0, 32'h0, 1'b0}},
      '{1'b0, '{1'b0, 32'h00010000, 32'h00000000, 32'h010E0000}, '{32'h0, 32'h0, 1'b0}},
      '{1'b0, '{1'b0, 32'h00000000, 32'h00010000, 32'hFFA60000}, '{32'h0, 32'h0, 1'b0}},
      '{1'b0, '{1'b0, 32'h00010000, 32'h00010000, 32'h01680000}, '{32'h0, 32'h0, 1'b0}},
      '{1'b0, '{1'b0, 32'h00010000, 32'h00000000, 32'h02D00000}, '{32'h0, 32'h0, 1'b0}},
      '{1'b0, '{1'b0, 32'h00018000, 32'hFFFDC000, 32'h002D0000}, '{32'h0, 32'h0, 1'b0}},
      '{1'b0, '{1'b1, 32'h00018000, 32'hFFFDC000, 32'h002D0000}, '{32'h0, 32'h0, 1'b0}},
      '{1'b0, '{1'b0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFD30000}, '{32'h0, 32'h0, 1'b0}},
      '{1'b0, '{1'b0, 32'h80000000, 32'h80000000, 32'h002D0000}, '{32'h0, 32'h0, 1'b0}},
      '{1'b0, '{1'b1, 32'h7FFFFFFF, 32'h00000000, 32'h00000000}, '{32'h0, 32'h0, 1'b0}},
      '{1'b0, '{1'b1, 32'h80000000, 32'h80000000, 32'h00000000}, '{32'h0, 32'h0, 1'b0}},
      '{1'b0, '{1'b0, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF}, '{32'h0, 32'h0, 1'b0}},
      '{1'b0, '{1'b1, 32'h7FFFFFFF, 32'h80000000, 32'h80000000}, '{32'h0, 32'h0, 1'b0}},
      '{1'b0, '{1'b0, 32'h00000001, 32'hFFFFFFFF, 32'h00010000}, '{32'h0, 32'h0, 1'b0}},
      '{1'b0, '{1'b1, 32'hFFFF8000, 32'h00008000, 32'h005A0000}, '{32'h0, 32'h0, 1'b0}},
      '{1'b0, '{1'b0, 32'h12345678, 32'h9ABCDEF0, 32'hFFFFFFFF}, '{32'h0, 32'h0, 1'b0}},
      '{1'b0, '{1'b1, 32'h00000000, 32'h00010000, 32'h00B40000}, '{32'h0, 32'h0, 1'b0}}
   };

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   vrd_pkg::vrd_req_type req_payload;
   logic                 rsp_valid;
   logic                 rsp_stall;
   vrd_pkg::vrd_rsp_type rsp_payload;

   job_type              job_list[$];
   vrd_pkg::vrd_rsp_type rotation_due[$];
   int                   n_taken      = 0;
   int                   n_checked    = 0;
   int                   n_errors     = 0;
   int                   quiet_cycles = 0;
   bit                   calm         = 1'b0;

   vector2_rotate_by_degrees i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #6 clock = ~clock;

   function automatic longint round_out(input longint v, input logic ceil_mode);
      if (ceil_mode) return ((v + ((64'sd1 <<< CEIL_SH) - 64'sd1)) >>> CEIL_SH) * 64'sd65536;
      if (GUARD == 0) return v;
      return (v + (64'sd1 <<< (GUARD - 1))) >>> GUARD;
   endfunction

   function automatic logic [32:0] clamp_word(input longint v);
      if (v > 64'sd2147483647) return {1'b1, 32'h7FFFFFFF};
      if (v < -64'sd2147483648) return {1'b1, 32'h80000000};
      return {1'b0, v[31:0]};
   endfunction

   function automatic vrd_pkg::vrd_rsp_type rotate_predict(input vrd_pkg::vrd_req_type r);
      longint               vx, vy, deg, rem, bam, x, y, z, xs, ys, nx, ny;
      logic [31:0]          th;
      logic [32:0]          cx, cy;
      vrd_pkg::vrd_rsp_type o;
      vx  = longint'($signed(r.vec_x));
      vy  = longint'($signed(r.vec_y));
      deg = longint'($signed(r.angle_deg));
      rem = deg % DEG_TURN;
      if (rem < 0) rem = rem + DEG_TURN;
      bam = (rem * 64'sd65536 + 64'sd180) / 64'sd360;
      th  = 32'd0 - bam[31:0];
      z   = longint'($signed(th));
      x   = (vx * K_INV + (64'sd1 <<< (GAIN_SH - 1))) >>> GAIN_SH;
      y   = (vy * K_INV + (64'sd1 <<< (GAIN_SH - 1))) >>> GAIN_SH;
      if (z > QUARTER) begin
         z = z - HALF;
         x = -x;
         y = -y;
      end else if (z < -QUARTER) begin
         z = z + HALF;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < N_STAGES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            nx = x - ys;
            ny = y + xs;
            z  = z - ATAN_TAB[i];
         end else begin
            nx = x + ys;
            ny = y - xs;
            z  = z + ATAN_TAB[i];
         end
         x = nx;
         y = ny;
      end
      cx = clamp_word(round_out(x, r.mode));
      cy = clamp_word(round_out(y, r.mode));
      o.rotated_x = cx[31:0];
      o.rotated_y = cy[31:0];
      o.saturated = cx[32] | cy[32];
      return o;
   endfunction

   function automatic logic [31:0] rand_component();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom;
         4, 5, 6:    return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
         7: begin
            case ($urandom_range(0, 4))
               0:       return 32'h7FFFFFFF;
               1:       return 32'h80000000;
               2:       return 32'hFFFFFFFF;
               3:       return 32'h00000001;
               default: return 32'h00000000;
            endcase
         end
         default:    return $signed($urandom) >>> $urandom_range(1, 16);
      endcase
   endfunction

   function automatic logic [31:0] rand_angle();
      int k;
      k = int'($urandom_range(0, 32)) - 16;
      case ($urandom_range(0, 9))
         0, 1, 2: return $urandom;
         3, 4, 5: return 32'($urandom_range(0, 1440 << 16)) - 32'(720 << 16);
         6, 7:    return 32'(k * (45 << 16) + int'($urandom_range(0, 16)) - 8);
         8:       return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
         default: return 32'(k * (360 << 16));
      endcase
   endfunction

   function automatic int draw_wait();
      if (calm) return 0;
      return $urandom_range(0, 15);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      n_errors++;
   endtask

   task automatic build_jobs();
      job_type j;
      foreach (DIRECTED_JOBS[d]) job_list.push_back(DIRECTED_JOBS[d]);
      repeat (N_RANDOM) begin
         j               = '0;
         j.req.mode      = 1'($urandom_range(0, 1));
         j.req.vec_x     = rand_component();
         j.req.vec_y     = rand_component();
         j.req.angle_deg = rand_angle();
         job_list.push_back(j);
      end
   endtask

   // scoreboard: expectation on each input transfer, compare on each output transfer
   always @(posedge clock) begin
      vrd_pkg::vrd_rsp_type want;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (req_valid && !req_stall) begin
            if (job_list[n_taken].typed) rotation_due.push_back(job_list[n_taken].want);
            else rotation_due.push_back(rotate_predict(req_payload));
            n_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (rotation_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result %h", rsp_payload));
            end else begin
               want = rotation_due.pop_front();
               if (rsp_payload.rotated_x !== want.rotated_x)
                  report_mismatch($sformatf("result %0d rotated_x %h, want %h",
                                            n_checked, rsp_payload.rotated_x, want.rotated_x));
               if (rsp_payload.rotated_y !== want.rotated_y)
                  report_mismatch($sformatf("result %0d rotated_y %h, want %h",
                                            n_checked, rsp_payload.rotated_y, want.rotated_y));
               if (rsp_payload.saturated !== want.saturated)
                  report_mismatch($sformatf("result %0d saturated %b, want %b",
                                            n_checked, rsp_payload.saturated, want.saturated));
            end
            n_checked++;
         end
      end
   end

   // result side back-pressure
   initial begin
      int hold;
      rsp_stall = 1'b0;
      wait (!reset);
      forever begin
         hold = draw_wait();
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      wait (!reset);
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

   // sender
   initial begin
      int gap;
      int total;
      req_valid   = 1'b0;
      req_payload = '0;
      reset       = 1'b1;
      build_jobs();
      total = job_list.size();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      gap = draw_wait();
      for (int k = 0; k < total; k++) begin
         if (k >= N_DIRECTED && (k - N_DIRECTED) % 64 == 0) calm = ($urandom_range(0, 3) == 0);
         repeat (gap) @(posedge clock);
         req_valid   <= 1'b1;
         req_payload <= job_list[k].req;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         gap = draw_wait();
         if (k == N_DIRECTED - 1) begin
            // hold off until the directed results are all back
            req_valid <= 1'b0;
            @(posedge clock);
            while (rotation_due.size() != 0) @(posedge clock);
         end else if (gap != 0 || k == total - 1) begin
            req_valid <= 1'b0;
         end
      end
      while (rotation_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (rotation_due.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", rotation_due.size()));
      if (n_errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/vrd_pkg.sv
hw/rtl/vrd_front.sv
hw/rtl/vrd_cordic.sv
hw/rtl/vrd_out_buffer.sv
hw/rtl/vector2_rotate_by_degrees.sv
bench/tb_vector2_rotate_by_degrees.sv
